// File: hw/rtl/ed_pkg.sv
`default_nettype none

package ed_pkg;

    localparam int ELEM_WIDTH  = 16;
    localparam int DIFF_WIDTH  = ELEM_WIDTH + 1;
    localparam int SQ_WIDTH    = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH   = 42;
    localparam int ROOT_WIDTH  = SUM_WIDTH / 2;
    localparam int REM_WIDTH   = ROOT_WIDTH + 3;
    localparam int STEP_WIDTH  = $clog2(ROOT_WIDTH);
    localparam int ED_QUEUE_DEPTH = 4;

    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] a_element;
        logic signed [ELEM_WIDTH-1:0] b_element;
        logic                         last_pair;
    } ed_in_t;

    typedef struct packed {
        logic [SUM_WIDTH-1:0] distance;
        logic                 saturated;
    } ed_out_t;

    typedef struct packed {
        logic [SUM_WIDTH-1:0] sum;
        logic                 clipped;
    } ed_acc_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_ROOT,
        BACK_DONE
    } ed_back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/ed_queue.sv
`default_nettype none

module ed_queue #(
    parameter int DEPTH = ed_pkg::ED_QUEUE_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire ed_pkg::ed_acc_t              wr_data,
    input  wire logic                         rd_en,
    output      ed_pkg::ed_acc_t              rd_data,
    output      logic [$clog2(DEPTH+1)-1:0]   count
);
    import ed_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    ed_acc_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ed_front.sv
`default_nettype none

module ed_front #(
    parameter int DEPTH = ed_pkg::ED_QUEUE_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire ed_pkg::ed_in_t               pair,
    output      logic                         full,
    input  wire logic [$clog2(DEPTH+1)-1:0]   q_count,
    output      logic                         q_wr_en,
    output      ed_pkg::ed_acc_t              q_wr_data
);
    import ed_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                         accept;
    logic signed [DIFF_WIDTH-1:0] diff;
    logic [DIFF_WIDTH-1:0]        mag;
    logic [CNT_W:0]               pending;
    logic [SUM_WIDTH:0]           total;
    logic                         over;
    logic [SUM_WIDTH-1:0]         sum_upd;
    logic                         clip_upd;

    logic                  s1_valid_reg, s1_last_reg;
    logic [DIFF_WIDTH-1:0] s1_mag_reg;
    logic                  s2_valid_reg, s2_last_reg;
    logic [SQ_WIDTH-1:0]   s2_sq_reg;
    logic [SUM_WIDTH-1:0]  sum_reg, sum_next;
    logic                  clip_reg, clip_next;

    // results already on their way to the queue count against its room
    assign pending = {1'b0, q_count}
                   + (CNT_W+1)'(s1_valid_reg && s1_last_reg)
                   + (CNT_W+1)'(s2_valid_reg && s2_last_reg);
    assign full    = (pending >= (CNT_W+1)'(DEPTH));
    assign accept  = push && !full;

    assign diff = DIFF_WIDTH'(pair.a_element) - DIFF_WIDTH'(pair.b_element);
    assign mag  = diff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff) : DIFF_WIDTH'(diff);

    // saturating accumulate
    assign total    = {1'b0, sum_reg} + (SUM_WIDTH+1)'(s2_sq_reg);
    assign over     = total[SUM_WIDTH];
    assign sum_upd  = over ? SUM_MAX : total[SUM_WIDTH-1:0];
    assign clip_upd = clip_reg || over;

    always_comb
    begin
        sum_next  = sum_reg;
        clip_next = clip_reg;
        if (s2_valid_reg)
        begin
            sum_next  = s2_last_reg ? '0 : sum_upd;
            clip_next = s2_last_reg ? 1'b0 : clip_upd;
        end
    end

    assign q_wr_en           = s2_valid_reg && s2_last_reg;
    assign q_wr_data.sum     = sum_upd;
    assign q_wr_data.clipped = clip_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            sum_reg      <= '0;
            clip_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= pair.last_pair;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
            sum_reg      <= sum_next;
            clip_reg     <= clip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mag_reg <= mag;
        s2_sq_reg  <= s1_mag_reg * s1_mag_reg;
    end

endmodule

`default_nettype wire

// File: hw/rtl/ed_back.sv
`default_nettype none

module ed_back #(
    parameter int DEPTH = ed_pkg::ED_QUEUE_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_data,
    input  wire logic [$clog2(DEPTH+1)-1:0]   q_count,
    input  wire ed_pkg::ed_acc_t              q_rd_data,
    output      logic                         q_rd_en,
    output      logic                         empty,
    input  wire logic                         pop,
    output      ed_pkg::ed_out_t              result
);
    import ed_pkg::*;

    ed_back_state_t state_reg, state_next;

    logic                  skip_root_reg;
    logic [SUM_WIDTH-1:0]  rad_reg;
    logic [REM_WIDTH-1:0]  rem_reg;
    logic [ROOT_WIDTH-1:0] root_reg;
    logic [STEP_WIDTH-1:0] step_reg;
    logic                  clip_reg;
    ed_out_t               out_reg;

    logic                  q_avail;
    logic                  load_direct;
    logic                  load_root;
    logic                  root_last;
    logic [REM_WIDTH-1:0]  rem_shift;
    logic [REM_WIDTH-1:0]  trial;
    logic                  take;
    logic [REM_WIDTH-1:0]  rem_step;
    logic [ROOT_WIDTH-1:0] root_step;

    assign q_avail   = (q_count != '0);
    assign root_last = (step_reg == '0);

    // one result bit per step
    assign rem_shift = {rem_reg[REM_WIDTH-3:0], rad_reg[SUM_WIDTH-1 -: 2]};
    assign trial     = REM_WIDTH'({root_reg, 2'b01});
    assign take      = (rem_shift >= trial);
    assign rem_step  = take ? rem_shift - trial : rem_shift;
    assign root_step = {root_reg[ROOT_WIDTH-2:0], take};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (q_avail)
                begin
                    state_next = skip_root_reg ? BACK_DONE : BACK_ROOT;
                end
            end
            BACK_ROOT:
            begin
                if (root_last)
                begin
                    state_next = BACK_DONE;
                end
            end
            BACK_DONE:
            begin
                if (pop)
                begin
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_rd_en     = 1'b0;
        load_direct = 1'b0;
        load_root   = 1'b0;
        empty       = 1'b1;
        unique case (state_reg)
            BACK_IDLE:
            begin
                q_rd_en     = q_avail;
                load_direct = q_avail && skip_root_reg;
                load_root   = q_avail && !skip_root_reg;
            end
            BACK_ROOT:
            begin
                empty = 1'b1;
            end
            BACK_DONE:
            begin
                empty = 1'b0;
            end
            default:
            begin
                empty = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            skip_root_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                skip_root_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_direct)
        begin
            out_reg.distance  <= q_rd_data.sum;
            out_reg.saturated <= q_rd_data.clipped;
        end
        if (load_root)
        begin
            rad_reg  <= q_rd_data.sum;
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= STEP_WIDTH'(ROOT_WIDTH - 1);
            clip_reg <= q_rd_data.clipped;
        end
        if (state_reg == BACK_ROOT)
        begin
            rad_reg  <= {rad_reg[SUM_WIDTH-3:0], 2'b00};
            rem_reg  <= rem_step;
            root_reg <= root_step;
            step_reg <= step_reg - 1'b1;
            if (root_last)
            begin
                out_reg.distance  <= SUM_WIDTH'(root_step);
                out_reg.saturated <= clip_reg;
            end
        end
    end

    assign result = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/euclidean_distance.sv
// channel   direction  handshake        payload
// pair      in         push / full      ed_in_t  (a_element, b_element, last_pair)
// result    out        pop / empty      ed_out_t (distance, saturated)
// config    in         cfg_we           cfg_data (skip_root)
//
// one pair per cycle while full is low; last pairs pass s1 and s2 into the result queue
// squared mode: the queue entry is read in BACK_IDLE and shown in BACK_DONE until popped
// root mode: digit-by-digit square root, read in BACK_IDLE, built in BACK_ROOT and shown
//   in BACK_DONE; either mode reads the next queue entry only after the result is popped
// full rises when the result queue plus last pairs in flight reach its depth
// rst_n clears the accumulator, the queue, the back-end state and skip_root
`default_nettype none

module euclidean_distance #(
    parameter int QUEUE_DEPTH = ed_pkg::ED_QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output      logic            full,
    input  wire ed_pkg::ed_in_t  pair,
    output      logic            empty,
    input  wire logic            pop,
    output      ed_pkg::ed_out_t result,
    input  wire logic            cfg_we,
    input  wire logic            cfg_data
);
    import ed_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             q_wr_en;
    ed_acc_t          q_wr_data;
    logic             q_rd_en;
    ed_acc_t          q_rd_data;
    logic [CNT_W-1:0] q_count;

    ed_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pair     (pair),
        .full     (full),
        .q_count  (q_count),
        .q_wr_en  (q_wr_en),
        .q_wr_data(q_wr_data)
    );

    ed_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_wr_en),
        .wr_data(q_wr_data),
        .rd_en  (q_rd_en),
        .rd_data(q_rd_data),
        .count  (q_count)
    );

    ed_back #(
        .DEPTH(QUEUE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_count  (q_count),
        .q_rd_data(q_rd_data),
        .q_rd_en  (q_rd_en),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

`default_nettype wire

// File: hw/rtl/ed_checker.sv
`default_nettype none

module ed_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            empty,
    input wire logic            pop,
    input wire ed_pkg::ed_out_t result
);
    import ed_pkg::*;

    localparam logic [SUM_WIDTH-1:0] ROOT_MAX = SUM_WIDTH'({ROOT_WIDTH{1'b1}});

    // waiting result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed while waiting");

    // one result register: a pop always drains it
    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop |=> empty)
        else $error("result shown twice");

    // a clipped sum reads as full scale or its root
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.saturated |->
            result.distance == SUM_MAX || result.distance == ROOT_MAX)
        else $error("saturated result has wrong value");

    // nothing is shown out of reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result shown after reset");

endmodule

bind euclidean_distance ed_checker u_ed_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .result(result)
);

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
    import ed_pkg::*;

    localparam bit MODE_ROOT = 1'b0;
    localparam bit MODE_SQUARED = 1'b1;
    localparam longint unsigned SUM_TOP = (64'd1 << SUM_WIDTH) - 64'd1;
    localparam longint unsigned MAX_DIFF = 64'd65535;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_PHASES = 5;
    localparam int PAIRS_PER_PHASE = 40;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    ed_in_t pair;
    logic empty;
    logic pop;
    ed_out_t result;
    logic cfg_we;
    logic cfg_data;

    longint unsigned acc_sum;
    bit acc_clipped;
    bit skip_root_cfg;
    bit idle_on;
    ed_out_t pending_distances[$];
    int errors;
    int pairs_sent;
    int roots_expected;
    int squares_expected;
    int clipped_expected;

    euclidean_distance dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .pair    (pair),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << ROOT_WIDTH;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // squared difference into the running sum, distance queued on the last pair
    function automatic void accumulate_pair(ed_in_t p);
        longint d;
        longint unsigned mag;
        longint unsigned sq;
        ed_out_t r;
        d = longint'($signed(p.a_element)) - longint'($signed(p.b_element));
        mag = (d < 0) ? longint'(-d) : longint'(d);
        sq = mag * mag;
        if (sq > SUM_TOP - acc_sum)
        begin
            acc_sum = SUM_TOP;
            acc_clipped = 1'b1;
        end
        else
            acc_sum = acc_sum + sq;
        if (p.last_pair)
        begin
            r.distance = (skip_root_cfg == MODE_SQUARED) ? acc_sum[SUM_WIDTH-1:0]
                                                         : SUM_WIDTH'(floor_root(acc_sum));
            r.saturated = acc_clipped;
            pending_distances.push_back(r);
            if (skip_root_cfg == MODE_SQUARED)
                squares_expected++;
            else
                roots_expected++;
            if (acc_clipped)
                clipped_expected++;
            acc_sum = 0;
            acc_clipped = 1'b0;
        end
    endfunction

    task automatic send_pair(logic [15:0] a, logic [15:0] b, bit last);
        ed_in_t p;
        p.a_element = a;
        p.b_element = b;
        p.last_pair = last;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push <= 1'b1;
        pair <= p;
        do
            @(posedge clk);
        while (full);
        accumulate_pair(p);
        pairs_sent++;
    endtask

    // difference d as (d - 32768) against -32768
    task automatic send_diff(longint unsigned d, bit last);
        send_pair(16'(d) ^ 16'h8000, 16'h8000, last);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_skip_root(bit v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        skip_root_cfg = v;
    endtask

    task automatic test_squared_extremes();
        write_skip_root(MODE_SQUARED);
        send_pair(16'sd32767, -16'sd32768, 1'b1);
        send_pair(-16'sd32768, 16'sd32767, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(-16'sd32768, -16'sd32768, 1'b1);
        send_pair(16'sd32767, 16'sd32767, 1'b1);
        send_pair(16'sd1, -16'sd1, 1'b0);
        send_pair(-16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd256, -16'sd256, 1'b1);
        send_pair(-16'sd32768, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd32767, 1'b0);
        send_pair(16'sd1, 16'sd0, 1'b1);
    endtask

    task automatic test_root_extremes();
        wait_drained();
        write_skip_root(MODE_ROOT);
        send_pair(16'sd3, 16'sd0, 1'b1);
        send_pair(16'sd2, 16'sd0, 1'b0);
        send_pair(16'sd0, -16'sd2, 1'b1);
        send_pair(16'sd32767, -16'sd32768, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(-16'sd32768, 16'sd32767, 1'b0);
        send_pair(16'sd32767, -16'sd32768, 1'b1);
        send_pair(16'sd1, 16'sd0, 1'b1);
        send_pair(-16'sd1, -16'sd1, 1'b1);
        send_pair(16'sd0, 16'sd1, 1'b1);
    endtask

    // fill the sum exactly to its top without clipping, then overflow on the last pair
    task automatic test_saturation();
        longint unsigned rest;
        longint unsigned d;
        wait_drained();
        write_skip_root(MODE_ROOT);
        repeat (1024) send_diff(MAX_DIFF, 1'b0);
        rest = SUM_TOP - 64'd1024 * MAX_DIFF * MAX_DIFF;
        while (rest > 0)
        begin
            d = floor_root(rest);
            if (d > MAX_DIFF)
                d = MAX_DIFF;
            send_diff(d, 1'b0);
            rest = rest - d * d;
        end
        send_diff(1, 1'b1);
        send_diff(5, 1'b1);
    endtask

    function automatic logic [15:0] rand_element();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_random();
        int len;
        int count;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            write_skip_root(bit'($urandom_range(0, 1)));
            idle_on = (phase != 2) && (phase != RANDOM_PHASES - 1);
            count = 0;
            while (count < PAIRS_PER_PHASE)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48)
                                                  : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_pair(rand_element(), rand_element(), i == len - 1);
                count += len;
            end
        end
    endtask

    // result side: random stall bursts while idling is on
    initial
    begin
        pop <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_distance
        ed_out_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_distances.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, %s %0d saturated %0b",
                         $time, "actual distance", result.distance, result.saturated);
                errors++;
            end
            else
            begin
                want = pending_distances.pop_front();
                if (result.distance !== want.distance)
                begin
                    $display("%0t: distance mismatch, expected %0d, actual %0d",
                             $time, want.distance, result.distance);
                    errors++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $display("%0t: saturated mismatch, expected %0b, actual %0b",
                             $time, want.saturated, result.saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        pair <= '0;
        cfg_we <= 1'b0;
        cfg_data <= 1'b0;
        acc_sum = 0;
        acc_clipped = 1'b0;
        skip_root_cfg = MODE_ROOT;
        idle_on = 1'b1;
        errors = 0;
        pairs_sent = 0;
        roots_expected = 0;
        squares_expected = 0;
        clipped_expected = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_squared_extremes();
        test_root_extremes();
        test_saturation();
        test_random();
        push <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d pairs giving %0d root and %0d squared distances",
                 pairs_sent, roots_expected, squares_expected);
        $display("%0d of them saturated, including an exact fill of the sum",
                 clipped_expected);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
